// ===== hw/rtl/crbm_pkg.sv =====
// Shared constants, codes and types for the circular-region block mosaic
package crbm_pkg;

    localparam int unsigned COORD_W   = 10;
    localparam int unsigned PIX_W     = 8;
    localparam int unsigned CX_W      = 10;
    localparam int unsigned CY_W      = 10;
    localparam int unsigned RAD_W     = 11;
    localparam int unsigned BPR_W     = 7;
    localparam int unsigned REGION_W  = 2;
    localparam int unsigned SUM_W     = 16;
    localparam int unsigned SUM_DEPTH = 4096;
    localparam int unsigned ADDR_W    = $clog2(SUM_DEPTH);
    localparam int unsigned REG_CNT   = 4;
    localparam int unsigned REG_IDX_W = $clog2(REG_CNT);
    localparam int unsigned APB_AW    = REG_IDX_W + 2;
    localparam int unsigned APB_DW    = 32;

    localparam int unsigned BLOCK_DFLT = 16;

    localparam logic [CX_W-1:0]  CENTER_X_RST = CX_W'(512);
    localparam logic [CY_W-1:0]  CENTER_Y_RST = CY_W'(502);
    localparam logic [RAD_W-1:0] RADIUS_RST   = RAD_W'(200);
    localparam logic [BPR_W-1:0] BPR_RST      = BPR_W'(64);

    localparam logic OP_ACCUM = 1'b0;
    localparam logic OP_EMIT  = 1'b1;

    localparam logic [REG_IDX_W-1:0] REG_CENTER_X = REG_IDX_W'(0);
    localparam logic [REG_IDX_W-1:0] REG_CENTER_Y = REG_IDX_W'(1);
    localparam logic [REG_IDX_W-1:0] REG_RADIUS   = REG_IDX_W'(2);
    localparam logic [REG_IDX_W-1:0] REG_BPR      = REG_IDX_W'(3);

    localparam logic [REGION_W-1:0] REGION_INSIDE   = REGION_W'(0);
    localparam logic [REGION_W-1:0] REGION_OUTSIDE  = REGION_W'(1);
    localparam logic [REGION_W-1:0] REGION_BOUNDARY = REGION_W'(2);

    localparam logic [PIX_W-1:0] PIX_MAX = '1;
    localparam logic [SUM_W-1:0] SUM_MAX = '1;

    typedef struct packed {
        logic [CX_W-1:0]  center_x;
        logic [CY_W-1:0]  center_y;
        logic [RAD_W-1:0] radius;
        logic [BPR_W-1:0] blocks_per_row;
    } t_cfg;

    typedef struct packed {
        logic                vld;
        logic                op;
        logic [PIX_W-1:0]    pix;
        logic [ADDR_W-1:0]   addr;
        logic                first;
        logic [REGION_W-1:0] region;
    } t_mem_req;

    typedef struct packed {
        logic                vld;
        logic [PIX_W-1:0]    pixel_out;
        logic [REGION_W-1:0] region;
    } t_res;

endpackage

// ===== hw/rtl/crbm_req_if.sv =====
// Request channel: operation, pixel coordinates and gray value
interface crbm_req_if;
    logic                          valid;
    logic                          ready;
    logic                          op;
    logic [crbm_pkg::COORD_W-1:0]  pix_x;
    logic [crbm_pkg::COORD_W-1:0]  pix_y;
    logic [crbm_pkg::PIX_W-1:0]    pixel_in;

    modport source (output valid, op, pix_x, pix_y, pixel_in, input ready);
    modport sink   (input valid, op, pix_x, pix_y, pixel_in, output ready);
endinterface

// ===== hw/rtl/crbm_res_if.sv =====
// Result channel: output gray value and circle region
interface crbm_res_if;
    logic                          valid;
    logic                          ready;
    logic [crbm_pkg::PIX_W-1:0]    pixel_out;
    logic [crbm_pkg::REGION_W-1:0] region;

    modport source (output valid, pixel_out, region, input ready);
    modport sink   (input valid, pixel_out, region, output ready);
endinterface

// ===== hw/rtl/circular_region_block_mosaic_core.sv =====
// Top level of the circular-region block mosaic
//
//  channel  | dir | handshake            | payload
//  ---------+-----+----------------------+----------------------------------
//  i_req    | in  | valid / ready        | op, pix_x, pix_y, pixel_in
//  o_res    | out | valid / ready        | pixel_out, region
//  apb      | in  | psel/penable, pready | paddr, pwdata, prdata (4 regs)
//
//  One request per cycle while the pipeline is not held; emits yield registered results.
//  Sum memory: one read and one write port, read data registered; a write in
//  flight is forwarded to the following read of the same block.
//  Reset is synchronous; the sum memory is not cleared (entries are written
//  at each block's first pixel). Output register plus one skid entry: ready
//  drops only once the skid entry is full, and then the whole pipeline holds.
module circular_region_block_mosaic_core #(
    parameter int unsigned BLOCK = crbm_pkg::BLOCK_DFLT
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    crbm_req_if.sink                    i_req,
    crbm_res_if.source                  o_res,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [crbm_pkg::APB_AW-1:0] paddr,
    input  logic [crbm_pkg::APB_DW-1:0] pwdata,
    output logic [crbm_pkg::APB_DW-1:0] prdata,
    output logic                        pready
);
    import crbm_pkg::*;

    t_cfg     cfg;
    t_mem_req mem_req;
    t_res     res;
    logic     en;

    crbm_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    crbm_front #(.BLOCK(BLOCK)) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_en      (en),
        .i_cfg     (cfg),
        .i_req     (i_req),
        .o_mem_req (mem_req)
    );

    crbm_sum #(.BLOCK(BLOCK)) u_sum (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_en      (en),
        .i_mem_req (mem_req),
        .o_res     (res)
    );

    crbm_obuf u_obuf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_res   (res),
        .o_en    (en),
        .o_res   (o_res)
    );

    a_stall_has_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_req.ready |-> o_res.valid)
        else $error("request side stalled with no result held");

    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(i_req.ready) |-> $past(o_res.valid && !o_res.ready))
        else $error("ready dropped without a blocked result");

    a_boundary_white: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid && (o_res.region == REGION_BOUNDARY) |-> o_res.pixel_out == PIX_MAX)
        else $error("boundary result is not white");

endmodule

// ===== hw/rtl/crbm_cfg.sv =====
// APB configuration registers
module crbm_cfg (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [crbm_pkg::APB_AW-1:0]   paddr,
    input  logic [crbm_pkg::APB_DW-1:0]   pwdata,
    output logic [crbm_pkg::APB_DW-1:0]   prdata,
    output logic                          pready,
    output crbm_pkg::t_cfg                o_cfg
);
    import crbm_pkg::*;

    t_cfg                 r_cfg;
    logic                 wr_en;
    logic [REG_IDX_W-1:0] idx;

    assign idx    = paddr[APB_AW-1:2];
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.center_x       <= CENTER_X_RST;
            r_cfg.center_y       <= CENTER_Y_RST;
            r_cfg.radius         <= RADIUS_RST;
            r_cfg.blocks_per_row <= BPR_RST;
        end else if (wr_en) begin
            case (idx)
                REG_CENTER_X: r_cfg.center_x       <= pwdata[CX_W-1:0];
                REG_CENTER_Y: r_cfg.center_y       <= pwdata[CY_W-1:0];
                REG_RADIUS:   r_cfg.radius         <= pwdata[RAD_W-1:0];
                REG_BPR:      r_cfg.blocks_per_row <= pwdata[BPR_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (idx)
            REG_CENTER_X: prdata = APB_DW'(r_cfg.center_x);
            REG_CENTER_Y: prdata = APB_DW'(r_cfg.center_y);
            REG_RADIUS:   prdata = APB_DW'(r_cfg.radius);
            REG_BPR:      prdata = APB_DW'(r_cfg.blocks_per_row);
            default:      prdata = '0;
        endcase
    end

endmodule

// ===== hw/rtl/crbm_front.sv =====
// Address and circle-test pipeline: block index, first-pixel flag, distance compare
module crbm_front #(
    parameter int unsigned BLOCK = crbm_pkg::BLOCK_DFLT
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  crbm_pkg::t_cfg     i_cfg,
    crbm_req_if.sink           i_req,
    output crbm_pkg::t_mem_req o_mem_req
);
    import crbm_pkg::*;

    // floor(v / BLOCK) for v < 2**COORD_W as (v * XM) >> XK
    localparam int unsigned XK   = COORD_W + $clog2(BLOCK);
    localparam int unsigned XM_W = COORD_W + 2;
    localparam logic [XM_W-1:0] XM =
        XM_W'(((longint'(1) << XK) + longint'(BLOCK) - 1) / longint'(BLOCK));
    localparam int unsigned Q_W  = $clog2(((1 << COORD_W) - 1) / BLOCK + 1);
    localparam int unsigned XP_W = COORD_W + XM_W;
    localparam int unsigned SQ_W = 2 * COORD_W;
    localparam int unsigned D2_W = SQ_W + 1;
    localparam int unsigned R2_W = 2 * RAD_W;
    localparam int unsigned CMP_W = (D2_W > R2_W) ? D2_W : R2_W;
    localparam int unsigned AF_W = Q_W + BPR_W + 1;

    // stage 1
    logic               r_s1_vld;
    logic               r_s1_op;
    logic [COORD_W-1:0] r_s1_x;
    logic [COORD_W-1:0] r_s1_y;
    logic [PIX_W-1:0]   r_s1_pix;
    logic [XP_W-1:0]    prod_x;
    logic [XP_W-1:0]    prod_y;
    logic [COORD_W-1:0] dx;
    logic [COORD_W-1:0] dy;

    // stage 2
    logic               r_s2_vld;
    logic               r_s2_op;
    logic [COORD_W-1:0] r_s2_x;
    logic [COORD_W-1:0] r_s2_y;
    logic [PIX_W-1:0]   r_s2_pix;
    logic [Q_W-1:0]     r_s2_bx;
    logic [Q_W-1:0]     r_s2_by;
    logic [COORD_W-1:0] r_s2_dx;
    logic [COORD_W-1:0] r_s2_dy;
    logic [AF_W-1:0]    addr_full;
    logic [COORD_W-1:0] rem_x;
    logic [COORD_W-1:0] rem_y;

    // stage 3
    logic               r_s3_vld;
    logic               r_s3_op;
    logic [PIX_W-1:0]   r_s3_pix;
    logic [ADDR_W-1:0]  r_s3_addr;
    logic               r_s3_first;
    logic [SQ_W-1:0]    r_s3_dx2;
    logic [SQ_W-1:0]    r_s3_dy2;
    logic [R2_W-1:0]    r_s3_r2;
    logic [CMP_W-1:0]   d2;
    logic [CMP_W-1:0]   r2;

    assign i_req.ready = i_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
            r_s2_vld <= 1'b0;
            r_s3_vld <= 1'b0;
        end else if (i_en) begin
            r_s1_vld <= i_req.valid;
            r_s2_vld <= r_s1_vld;
            r_s3_vld <= r_s2_vld;
        end
    end

    assign prod_x = XP_W'(r_s1_x) * XP_W'(XM);
    assign prod_y = XP_W'(r_s1_y) * XP_W'(XM);
    assign dx = (r_s1_x >= i_cfg.center_x) ? r_s1_x - i_cfg.center_x
                                           : i_cfg.center_x - r_s1_x;
    assign dy = (r_s1_y >= i_cfg.center_y) ? r_s1_y - i_cfg.center_y
                                           : i_cfg.center_y - r_s1_y;

    assign addr_full = AF_W'(r_s2_by) * AF_W'(i_cfg.blocks_per_row) + AF_W'(r_s2_bx);
    assign rem_x = r_s2_x - COORD_W'(r_s2_bx) * COORD_W'(BLOCK);
    assign rem_y = r_s2_y - COORD_W'(r_s2_by) * COORD_W'(BLOCK);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s1_op    <= i_req.op;
            r_s1_x     <= i_req.pix_x;
            r_s1_y     <= i_req.pix_y;
            r_s1_pix   <= i_req.pixel_in;

            r_s2_op    <= r_s1_op;
            r_s2_x     <= r_s1_x;
            r_s2_y     <= r_s1_y;
            r_s2_pix   <= r_s1_pix;
            r_s2_bx    <= Q_W'(prod_x >> XK);
            r_s2_by    <= Q_W'(prod_y >> XK);
            r_s2_dx    <= dx;
            r_s2_dy    <= dy;

            r_s3_op    <= r_s2_op;
            r_s3_pix   <= r_s2_pix;
            r_s3_addr  <= ADDR_W'(addr_full);
            r_s3_first <= (rem_x == '0) && (rem_y == '0);
            r_s3_dx2   <= SQ_W'(r_s2_dx) * SQ_W'(r_s2_dx);
            r_s3_dy2   <= SQ_W'(r_s2_dy) * SQ_W'(r_s2_dy);
            r_s3_r2    <= R2_W'(i_cfg.radius) * R2_W'(i_cfg.radius);
        end
    end

    assign d2 = CMP_W'(r_s3_dx2) + CMP_W'(r_s3_dy2);
    assign r2 = CMP_W'(r_s3_r2);

    always_comb begin
        o_mem_req.vld   = r_s3_vld;
        o_mem_req.op    = r_s3_op;
        o_mem_req.pix   = r_s3_pix;
        o_mem_req.addr  = r_s3_addr;
        o_mem_req.first = r_s3_first;
        if (d2 < r2) begin
            o_mem_req.region = REGION_INSIDE;
        end else if (d2 > r2) begin
            o_mem_req.region = REGION_OUTSIDE;
        end else begin
            o_mem_req.region = REGION_BOUNDARY;
        end
    end

endmodule

// ===== hw/rtl/crbm_sum.sv =====
// Block sum memory with read-modify-write, forwarding and averaging
module crbm_sum #(
    parameter int unsigned BLOCK = crbm_pkg::BLOCK_DFLT
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  crbm_pkg::t_mem_req i_mem_req,
    output crbm_pkg::t_res     o_res
);
    import crbm_pkg::*;

    // floor(sum / BLOCK**2) for a SUM_W-bit sum as (sum * AM) >> AK
    localparam int unsigned AREA = BLOCK * BLOCK;
    localparam int unsigned AK   = SUM_W + $clog2(AREA);
    localparam int unsigned AM_W = SUM_W + 2;
    localparam logic [AM_W-1:0] AM =
        AM_W'(((longint'(1) << AK) + longint'(AREA) - 1) / longint'(AREA));
    localparam int unsigned AP_W = SUM_W + AM_W;

    logic [SUM_W-1:0]    r_mem [SUM_DEPTH];
    logic [SUM_W-1:0]    r_rdata;

    logic                r_s4_vld;
    logic                r_s4_op;
    logic [PIX_W-1:0]    r_s4_pix;
    logic [ADDR_W-1:0]   r_s4_addr;
    logic                r_s4_first;
    logic [REGION_W-1:0] r_s4_region;
    logic                r_fwd_hit;
    logic [SUM_W-1:0]    r_fwd_dat;

    logic                r_s5_vld;
    logic [PIX_W-1:0]    r_s5_pix;
    logic [REGION_W-1:0] r_s5_region;
    logic [AP_W-1:0]     r_s5_prod;

    logic [SUM_W-1:0]    sum_cur;
    logic [SUM_W:0]      acc;
    logic [SUM_W-1:0]    n_sum;
    logic                wr_en;
    logic [AP_W-1:0]     avg_q;
    logic [PIX_W-1:0]    avg;

    assign sum_cur = r_fwd_hit ? r_fwd_dat : r_rdata;
    assign acc     = (SUM_W+1)'(sum_cur) + (SUM_W+1)'(r_s4_pix);
    assign n_sum   = r_s4_first ? SUM_W'(r_s4_pix)
                   : (acc[SUM_W] ? SUM_MAX : acc[SUM_W-1:0]);
    assign wr_en   = i_en && r_s4_vld && (r_s4_op == OP_ACCUM);

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_s4_addr] <= n_sum;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rdata <= r_mem[i_mem_req.addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s4_vld  <= 1'b0;
            r_s5_vld  <= 1'b0;
            r_fwd_hit <= 1'b0;
        end else if (i_en) begin
            r_s4_vld  <= i_mem_req.vld;
            r_s5_vld  <= r_s4_vld && (r_s4_op == OP_EMIT);
            r_fwd_hit <= wr_en && (r_s4_addr == i_mem_req.addr);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s4_op     <= i_mem_req.op;
            r_s4_pix    <= i_mem_req.pix;
            r_s4_addr   <= i_mem_req.addr;
            r_s4_first  <= i_mem_req.first;
            r_s4_region <= i_mem_req.region;
            r_fwd_dat   <= n_sum;

            r_s5_pix    <= r_s4_pix;
            r_s5_region <= r_s4_region;
            r_s5_prod   <= AP_W'(sum_cur) * AP_W'(AM);
        end
    end

    assign avg_q = r_s5_prod >> AK;
    assign avg   = (avg_q > AP_W'(PIX_MAX)) ? PIX_MAX : avg_q[PIX_W-1:0];

    always_comb begin
        o_res.vld    = r_s5_vld;
        o_res.region = r_s5_region;
        case (r_s5_region)
            REGION_INSIDE:  o_res.pixel_out = avg;
            REGION_OUTSIDE: o_res.pixel_out = r_s5_pix;
            default:        o_res.pixel_out = PIX_MAX;
        endcase
    end

endmodule

// ===== hw/rtl/crbm_obuf.sv =====
// Output register with one skid entry; drives the pipeline advance enable
module crbm_obuf (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  crbm_pkg::t_res i_res,
    output logic           o_en,
    crbm_res_if.source     o_res
);
    import crbm_pkg::*;

    logic                r_out_vld;
    logic [PIX_W-1:0]    r_out_pix;
    logic [REGION_W-1:0] r_out_region;
    logic                r_skid_vld;
    logic [PIX_W-1:0]    r_skid_pix;
    logic [REGION_W-1:0] r_skid_region;
    logic                push;
    logic                pop;
    logic                load_out;

    assign o_en     = !r_skid_vld;
    assign push     = o_en && i_res.vld;
    assign pop      = r_out_vld && o_res.ready;
    assign load_out = push && (!r_out_vld || pop);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld  <= 1'b0;
            r_skid_vld <= 1'b0;
        end else if (r_skid_vld) begin
            if (pop) begin
                r_skid_vld <= 1'b0;
            end
        end else if (push) begin
            r_out_vld  <= 1'b1;
            r_skid_vld <= !load_out;
        end else if (pop) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_vld && pop) begin
            r_out_pix    <= r_skid_pix;
            r_out_region <= r_skid_region;
        end else if (load_out) begin
            r_out_pix    <= i_res.pixel_out;
            r_out_region <= i_res.region;
        end
        if (push && !load_out) begin
            r_skid_pix    <= i_res.pixel_out;
            r_skid_region <= i_res.region;
        end
    end

    assign o_res.valid     = r_out_vld;
    assign o_res.pixel_out = r_out_pix;
    assign o_res.region    = r_out_region;

endmodule

// ===== sim/circular_region_block_mosaic_core_tb.sv =====
// Self-checking testbench for the circular-region block mosaic core
`timescale 1ns / 100ps

module circular_region_block_mosaic_core_tb;
    import crbm_pkg::*;

    localparam int unsigned BLK       = BLOCK_DFLT;
    localparam int unsigned DIM_MAX   = (1 << COORD_W) - 1;
    localparam int unsigned DRAIN_CYC = 16;
    localparam int unsigned HOLD_CYC  = 400;
    localparam int unsigned PHASES    = 9;
    localparam int unsigned PER_PHASE = 120;

    typedef struct packed {
        logic               op;
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [PIX_W-1:0]   pix;
    } t_pix_req;

    typedef struct packed {
        logic [PIX_W-1:0]    pixel_out;
        logic [REGION_W-1:0] region;
    } t_mosaic_px;

    logic i_clk = 1'b0;
    logic i_rst_n;

    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [APB_AW-1:0] paddr;
    logic [APB_DW-1:0] pwdata;
    logic [APB_DW-1:0] prdata;
    logic              pready;

    crbm_req_if req_if();
    crbm_res_if res_if();

    circular_region_block_mosaic_core u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_res   (res_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // current register values, shared by the stimulus and the prediction
    logic [CX_W-1:0]  cfg_cx  = CENTER_X_RST;
    logic [CY_W-1:0]  cfg_cy  = CENTER_Y_RST;
    logic [RAD_W-1:0] cfg_rad = RADIUS_RST;
    logic [BPR_W-1:0] cfg_bpr = BPR_RST;

    logic [SUM_W-1:0] block_sum [SUM_DEPTH];
    bit               sum_valid [SUM_DEPTH];

    t_pix_req   pix_req_q [$];
    t_mosaic_px expected_px_q [$];
    t_pix_req   drv_item;
    t_mosaic_px exp_px;

    int unsigned n_queued      = 0;
    int unsigned n_accepted    = 0;
    int unsigned n_errors      = 0;
    int unsigned send_idle_pct = 0;
    int unsigned recv_stall_pct = 0;
    int unsigned hold_req      = 0;
    int unsigned hold_taken    = 0;
    int unsigned hold_left     = 0;
    bit          req_fire      = 1'b0;

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    initial begin
        #400000;
        $display("FAILURE");
        $finish;
    end

    function automatic logic [ADDR_W-1:0] sum_addr(input int unsigned x, input int unsigned y);
        int unsigned v;
        v = (y / BLK) * cfg_bpr + x / BLK;
        return ADDR_W'(v);
    endfunction

    task automatic mosaic_step(input t_pix_req r);
        logic [ADDR_W-1:0] a;
        int unsigned       s;
        int unsigned       dx;
        int unsigned       dy;
        int unsigned       d2;
        int unsigned       r2;
        t_mosaic_px        o;
        a = sum_addr(r.x, r.y);
        if (r.op == OP_ACCUM) begin
            if (r.x % BLK == 0 && r.y % BLK == 0) begin
                s = r.pix;
            end else begin
                s = block_sum[a] + r.pix;
            end
            if (s > SUM_MAX) s = SUM_MAX;
            block_sum[a] = SUM_W'(s);
        end else begin
            dx = (r.x > cfg_cx) ? r.x - cfg_cx : cfg_cx - r.x;
            dy = (r.y > cfg_cy) ? r.y - cfg_cy : cfg_cy - r.y;
            d2 = dx * dx + dy * dy;
            r2 = cfg_rad * cfg_rad;
            if (d2 < r2) begin
                s = block_sum[a] / (BLK * BLK);
                o.pixel_out = (s > PIX_MAX) ? PIX_MAX : PIX_W'(s);
                o.region    = REGION_INSIDE;
            end else if (d2 > r2) begin
                o.pixel_out = r.pix;
                o.region    = REGION_OUTSIDE;
            end else begin
                o.pixel_out = PIX_MAX;
                o.region    = REGION_BOUNDARY;
            end
            expected_px_q.push_back(o);
        end
    endtask

    // result check first, then prediction of the request taken at this edge
    always @(posedge i_clk) begin
        if (i_rst_n && res_if.valid && res_if.ready) begin
            if (expected_px_q.size() == 0) begin
                n_errors++;
                $display("%0t: result with none expected, actual pixel_out %0d region %0d",
                         $time, res_if.pixel_out, res_if.region);
            end else begin
                exp_px = expected_px_q.pop_front();
                if (exp_px.pixel_out !== res_if.pixel_out) begin
                    n_errors++;
                    $display("%0t: pixel_out mismatch, expected %0d actual %0d",
                             $time, exp_px.pixel_out, res_if.pixel_out);
                end
                if (exp_px.region !== res_if.region) begin
                    n_errors++;
                    $display("%0t: region mismatch, expected %0d actual %0d",
                             $time, exp_px.region, res_if.region);
                end
            end
        end
        req_fire = i_rst_n && req_if.valid && req_if.ready;
        if (req_fire) begin
            n_accepted++;
            mosaic_step('{req_if.op, req_if.pix_x, req_if.pix_y, req_if.pixel_in});
        end
    end

    always @(negedge i_clk) begin
        if (!(req_if.valid && !req_fire)) begin
            if (pix_req_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                drv_item = pix_req_q.pop_front();
                req_if.valid    <= 1'b1;
                req_if.op       <= drv_item.op;
                req_if.pix_x    <= drv_item.x;
                req_if.pix_y    <= drv_item.y;
                req_if.pixel_in <= drv_item.pix;
            end else begin
                req_if.valid <= 1'b0;
            end
        end
    end

    // receiver: random stalls, plus a long hold-off on request
    always @(negedge i_clk) begin
        if (hold_req != hold_taken) begin
            hold_taken = hold_req;
            hold_left  = HOLD_CYC;
        end
        if (hold_left > 0) begin
            hold_left--;
            res_if.ready <= 1'b0;
        end else begin
            res_if.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    // a read of an unwritten sum entry is avoided by writing the block's first pixel first
    task automatic push_req(input logic op, input int unsigned x, input int unsigned y,
                            input int unsigned pix);
        logic [ADDR_W-1:0] a;
        a = sum_addr(x, y);
        if (!sum_valid[a] && (op == OP_EMIT || x % BLK != 0 || y % BLK != 0)) begin
            pix_req_q.push_back('{OP_ACCUM, COORD_W'(x / BLK * BLK), COORD_W'(y / BLK * BLK),
                                  PIX_W'($urandom_range(0, 255))});
            n_queued++;
        end
        if (op == OP_ACCUM) sum_valid[a] = 1'b1;
        pix_req_q.push_back('{op, COORD_W'(x), COORD_W'(y), PIX_W'(pix)});
        n_queued++;
    endtask

    function automatic int unsigned near(input int unsigned c);
        int v;
        v = int'(c) + int'($urandom_range(0, 2 * cfg_rad + 32)) - int'(cfg_rad) - 16;
        if (v < 0) v = 0;
        if (v > int'(DIM_MAX)) v = DIM_MAX;
        return v;
    endfunction

    task automatic gen_boundary();
        int r;
        int px;
        int py;
        int j;
        r = cfg_rad;
        j = $urandom_range(0, 5);
        if (j > 3 && r % 5 != 0) j = j % 4;
        px = cfg_cx;
        py = cfg_cy;
        case (j)
            0: px = px + r;
            1: px = px - r;
            2: py = py + r;
            3: py = py - r;
            4: begin
                px = px + 3 * r / 5;
                py = py + 4 * r / 5;
            end
            default: begin
                px = px - 4 * r / 5;
                py = py - 3 * r / 5;
            end
        endcase
        if (px >= 0 && px <= int'(DIM_MAX) && py >= 0 && py <= int'(DIM_MAX))
            push_req(OP_EMIT, px, py, $urandom_range(0, 255));
    endtask

    task automatic gen_random(input int unsigned n);
        int unsigned stop;
        int unsigned kind;
        int unsigned bx;
        int unsigned by;
        stop = n_queued + n;
        while (n_queued < stop) begin
            kind = $urandom_range(0, 99);
            if (kind < 60) begin
                if ($urandom_range(0, 1)) begin
                    bx = near(cfg_cx) / BLK * BLK;
                    by = near(cfg_cy) / BLK * BLK;
                end else begin
                    bx = $urandom_range(0, DIM_MAX) / BLK * BLK;
                    by = $urandom_range(0, DIM_MAX) / BLK * BLK;
                end
                push_req(OP_ACCUM, bx, by, $urandom_range(0, 255));
                repeat ($urandom_range(1, 12))
                    push_req(OP_ACCUM, bx + $urandom_range(0, BLK - 1),
                             by + $urandom_range(0, BLK - 1), $urandom_range(0, 255));
                repeat ($urandom_range(1, 4))
                    push_req(OP_EMIT, bx + $urandom_range(0, BLK - 1),
                             by + $urandom_range(0, BLK - 1), $urandom_range(0, 255));
            end else if (kind < 75) begin
                gen_boundary();
            end else begin
                push_req(1'($urandom_range(0, 1)), $urandom_range(0, DIM_MAX),
                         $urandom_range(0, DIM_MAX), $urandom_range(0, 255));
            end
        end
    endtask

    task automatic cfg_write(input logic [REG_IDX_W-1:0] idx, input int unsigned v);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= APB_DW'(v);
        @(negedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_CENTER_X: cfg_cx  = CX_W'(v);
            REG_CENTER_Y: cfg_cy  = CY_W'(v);
            REG_RADIUS:   cfg_rad = RAD_W'(v);
            REG_BPR:      cfg_bpr = BPR_W'(v);
            default: ;
        endcase
    endtask

    task automatic set_cfg(input int unsigned cx, input int unsigned cy, input int unsigned rad,
                           input int unsigned bpr);
        cfg_write(REG_CENTER_X, cx);
        cfg_write(REG_CENTER_Y, cy);
        cfg_write(REG_RADIUS, rad);
        cfg_write(REG_BPR, bpr);
    endtask

    task automatic set_idle(input int unsigned mode);
        case (mode)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 85; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 85; end
            default: begin send_idle_pct = 9; recv_stall_pct = 9; end
        endcase
    endtask

    task automatic wait_drained();
        while (n_accepted != n_queued || expected_px_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYC) @(posedge i_clk);
    endtask

    initial begin
        i_rst_n         = 1'b0;
        req_if.valid    = 1'b0;
        req_if.op       = OP_ACCUM;
        req_if.pix_x    = '0;
        req_if.pix_y    = '0;
        req_if.pixel_in = '0;
        res_if.ready    = 1'b0;
        psel            = 1'b0;
        penable         = 1'b0;
        pwrite          = 1'b0;
        paddr           = '0;
        pwdata          = '0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: reset settings, circle of radius 200 around (512, 502)
        set_idle(0);
        push_req(OP_ACCUM, 512, 496, 255);
        push_req(OP_ACCUM, 513, 497, 255);
        push_req(OP_ACCUM, 527, 511, 0);
        push_req(OP_EMIT, 512, 502, 0);
        push_req(OP_EMIT, 520, 500, 255);
        push_req(OP_EMIT, 712, 502, 0);
        push_req(OP_EMIT, 312, 502, 255);
        push_req(OP_EMIT, 512, 302, 17);
        push_req(OP_EMIT, 512, 702, 0);
        push_req(OP_EMIT, 632, 662, 1);
        push_req(OP_EMIT, 711, 502, 0);
        push_req(OP_EMIT, 713, 502, 0);
        push_req(OP_ACCUM, 1023, 1023, 255);
        push_req(OP_EMIT, 1023, 1023, 170);
        push_req(OP_ACCUM, 0, 0, 0);
        push_req(OP_EMIT, 0, 0, 85);
        push_req(OP_ACCUM, 0, 1023, 128);
        push_req(OP_EMIT, 1023, 0, 255);
        push_req(OP_ACCUM, 1008, 1008, 1);
        push_req(OP_EMIT, 1010, 1015, 0);

        // sum saturation: far more adds of full white than one block holds
        push_req(OP_ACCUM, 512, 496, 255);
        repeat (299)
            push_req(OP_ACCUM, 512 + $urandom_range(1, BLK - 1), 496 + $urandom_range(0, BLK - 1),
                     255);
        push_req(OP_EMIT, 515, 500, 0);

        // one complete block inside the circle
        for (int yy = 0; yy < BLK; yy++)
            for (int xx = 0; xx < BLK; xx++)
                push_req(OP_ACCUM, 496 + xx, 480 + yy, $urandom_range(0, 255));
        repeat (4)
            push_req(OP_EMIT, 496 + $urandom_range(0, BLK - 1), 480 + $urandom_range(0, BLK - 1),
                     $urandom_range(0, 255));
        gen_random(PER_PHASE / 2);
        wait_drained();

        for (int unsigned p = 1; p <= PHASES; p++) begin
            case (p)
                1: set_cfg(0, DIM_MAX, 1448, 1);
                2: set_cfg(DIM_MAX, 0, 0, 64);
                3: set_cfg(256, 768, 300, 0);
                4: set_cfg($urandom_range(0, DIM_MAX), $urandom_range(0, DIM_MAX),
                           $urandom_range(0, 600), $urandom_range(1, 64));
                5: set_cfg(640, 384, 125, 127);
                default: set_cfg($urandom_range(0, DIM_MAX), $urandom_range(0, DIM_MAX),
                                 $urandom_range(0, 800), $urandom_range(0, 127));
            endcase
            set_idle(p % 4);
            if (p == 4) hold_req++;
            gen_random(PER_PHASE);
            wait_drained();
        end

        if (n_errors == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
